// ----- hdl/srld_pkg.sv -----
// shared types and constants of the sprite decoder core
package srld_pkg;

    localparam int HISTORY_DEPTH_DEF = 2048;
    localparam int LANES             = 8;
    localparam logic [23:0] POS_MAX  = 24'hFFFFFF;

    localparam logic [2:0] FMT_RAW     = 3'd0;
    localparam logic [2:0] FMT_INVALID = 3'd1;
    localparam logic [2:0] FMT_RLE8    = 3'd2;
    localparam logic [2:0] FMT_RLE5    = 3'd3;
    localparam logic [2:0] FMT_LZ5     = 3'd4;

    localparam logic CFG_FORMAT  = 1'b0;
    localparam logic CFG_SURFACE = 1'b1;

    localparam logic MODE_PALETTE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RUN,
        ST_CPRD,
        ST_CPEM,
        ST_END
    } t_state;

    typedef enum logic [3:0] {
        PH_START,
        PH_RLE8_COLOR,
        PH_R5_LEN,
        PH_R5_COLOR,
        PH_R5_GROUP,
        PH_LZ_PACKET,
        PH_LZ_LONGRLE,
        PH_LZ_SHORTOFF,
        PH_LZ_LONGOFF,
        PH_LZ_LONGLEN
    } t_phase;

endpackage

// ----- hdl/sprite_rle_lz5_decoder_core.sv -----
// sprite decoder core: palette load, raw/rle8/rle5/lz5 decode, results of up to eight pixels
//
// channel  | direction | handshake             | payload
// input    | in        | i_valid / o_stall     | mode, palette_index, rgb, data_byte, last_byte
// result   | out       | o_valid / i_stall     | start_index, pixel_count, lane0..7, run_end, done
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// a palette write is stored as the input takes it; a data byte stalls the input through the
// decode state, the run or copy states (a copy reads the history, then writes the pixel
// back), the closing state and the drain of the emit stage; then the next byte is taken
// palette and pixel history are one-port-read synchronous memories; a copy source
// before position 0 gives zero, so reset leaves history untouched (no clearing pass)
// a stalled result freezes the pixel engine; a new byte waits for an idle engine and emit stage
module sprite_rle_lz5_decoder_core #(
    parameter int HISTORY_DEPTH = srld_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_palette_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_start_index,
    output logic [3:0]  o_pixel_count,
    output logic [31:0] o_lane0,
    output logic [31:0] o_lane1,
    output logic [31:0] o_lane2,
    output logic [31:0] o_lane3,
    output logic [31:0] o_lane4,
    output logic [31:0] o_lane5,
    output logic [31:0] o_lane6,
    output logic [31:0] o_lane7,
    output logic        o_run_end,
    output logic        o_sprite_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

    logic [7:0]  r_hist [HISTORY_DEPTH];
    logic [23:0] r_pal  [256];

    srld_pkg::t_state r_state, n_state;
    srld_pkg::t_phase r_phase, n_phase;
    logic [7:0]    r_byte;
    logic          r_last;
    logic [2:0]    r_skip, n_skip;
    logic [23:0]   r_pos, n_pos;
    logic [AW-1:0] r_wa, n_wa;
    logic [7:0]    r_ctrl, n_ctrl;
    logic [3:0]    r_slot, n_slot;
    logic [1:0]    r_scc, n_scc;
    logic [7:0]    r_recyc, n_recyc;
    logic [7:0]    r_held, n_held;
    logic [9:0]    r_hrun, n_hrun;
    logic [6:0]    r_gbl, n_gbl;
    logic [8:0]    r_cnt, n_cnt;
    logic [7:0]    r_color, n_color;
    logic [10:0]   r_off, n_off;
    logic          r_src_zero, n_src_zero;
    logic [2:0]    r_format;
    logic [23:0]   r_surf;

    logic [7:0]    r_hist_q;
    logic [23:0]   r_pal_q;
    logic [AW-1:0] hist_raddr;

    // emit stage towards the lane collector
    logic          e_pix, e_end;
    logic [7:0]    e_color;
    logic          r_a_pix, r_a_end, r_a_keep, r_a_nz, r_a_last;
    logic [23:0]   r_a_pos;

    logic [31:0]   r_acc_lane [srld_pkg::LANES];
    logic [3:0]    r_acc_cnt;
    logic [23:0]   r_acc_start;

    logic [31:0]   r_o_lane [srld_pkg::LANES];
    logic          r_o_vld, r_o_run_end, r_o_done;
    logic [3:0]    r_o_cnt;
    logic [23:0]   r_o_start;

    logic en, in_acc, cfg_wr, cfg_fmt, do_clear;
    logic a_take, a_move;
    logic [31:0] a_pixel;

    assign en      = !r_o_vld || !i_stall;
    assign o_stall = (r_state != srld_pkg::ST_IDLE) || r_a_pix || r_a_end;
    assign in_acc  = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr  = i_cfg_valid;
    assign cfg_fmt = cfg_wr && (i_cfg_index == srld_pkg::CFG_FORMAT);

    // decode and pixel sequencing
    always_comb begin
        logic [8:0]  d_len;
        logic        d_copy;
        logic [10:0] d_off;
        logic [7:0]  d_color;
        logic [6:0]  len6;
        logic [2:0]  sh;
        logic [7:0]  b;
        logic [AW:0] diff;
        d_len = '0;
        d_copy = 1'b0;
        d_off = '0;
        d_color = '0;
        len6 = '0;
        sh = '0;
        b = r_byte;
        diff = '0;
        n_state = r_state;
        n_phase = r_phase;
        n_skip = r_skip;
        n_pos = r_pos;
        n_wa = r_wa;
        n_ctrl = r_ctrl;
        n_slot = r_slot;
        n_scc = r_scc;
        n_recyc = r_recyc;
        n_held = r_held;
        n_hrun = r_hrun;
        n_gbl = r_gbl;
        n_cnt = r_cnt;
        n_color = r_color;
        n_off = r_off;
        n_src_zero = r_src_zero;
        e_pix = 1'b0;
        e_end = 1'b0;
        e_color = '0;
        do_clear = 1'b0;
        hist_raddr = '0;
        unique case (r_state)
            srld_pkg::ST_IDLE: begin
            end
            srld_pkg::ST_DECODE: begin
                if (r_skip < 3'd4) begin
                    n_skip = r_skip + 3'd1;
                end else begin
                    case (r_format)
                        srld_pkg::FMT_RAW: begin
                            d_len = 9'd1;
                            d_color = b;
                        end
                        srld_pkg::FMT_RLE8: begin
                            if (r_phase == srld_pkg::PH_RLE8_COLOR) begin
                                d_len = r_hrun[8:0];
                                d_color = b;
                                n_phase = srld_pkg::PH_START;
                            end else if (b[7:6] == 2'b01) begin
                                n_hrun = {4'd0, b[5:0]};
                                n_phase = srld_pkg::PH_RLE8_COLOR;
                            end else begin
                                d_len = 9'd1;
                                d_color = b;
                            end
                        end
                        srld_pkg::FMT_RLE5: begin
                            case (r_phase)
                                srld_pkg::PH_R5_LEN: begin
                                    n_gbl = b[6:0];
                                    if (b[7]) begin
                                        n_phase = srld_pkg::PH_R5_COLOR;
                                    end else begin
                                        d_len = r_hrun[8:0] + 9'd1;
                                        n_phase = (b[6:0] != 7'd0) ? srld_pkg::PH_R5_GROUP
                                                                   : srld_pkg::PH_START;
                                    end
                                end
                                srld_pkg::PH_R5_COLOR: begin
                                    d_len = r_hrun[8:0] + 9'd1;
                                    d_color = b;
                                    n_phase = (r_gbl != 7'd0) ? srld_pkg::PH_R5_GROUP
                                                              : srld_pkg::PH_START;
                                end
                                srld_pkg::PH_R5_GROUP: begin
                                    d_len = {6'd0, b[7:5]} + 9'd1;
                                    d_color = {3'd0, b[4:0]};
                                    n_gbl = r_gbl - 7'd1;
                                    if (n_gbl == 7'd0) n_phase = srld_pkg::PH_START;
                                end
                                default: begin
                                    n_hrun = {2'd0, b};
                                    n_phase = srld_pkg::PH_R5_LEN;
                                end
                            endcase
                        end
                        srld_pkg::FMT_LZ5: begin
                            case (r_phase)
                                srld_pkg::PH_LZ_PACKET: begin
                                    if (!r_ctrl[r_slot[2:0]]) begin
                                        if (b[7:5] != 3'd0) begin
                                            d_len = {6'd0, b[7:5]};
                                            d_color = {3'd0, b[4:0]};
                                            n_slot = r_slot + 4'd1;
                                        end else begin
                                            n_held = b;
                                            n_phase = srld_pkg::PH_LZ_LONGRLE;
                                        end
                                    end else if (b[5:0] != 6'd0) begin
                                        len6 = {1'b0, b[5:0]} + 7'd1;
                                        n_scc = r_scc + 2'd1;
                                        if (r_scc == 2'd0) begin
                                            d_len = {2'd0, len6};
                                            d_copy = 1'b1;
                                            d_off = {3'd0, r_recyc | {6'd0, b[7:6]}} + 11'd1;
                                            n_recyc = '0;
                                            n_slot = r_slot + 4'd1;
                                        end else begin
                                            sh = {r_scc - 2'd1, 1'b0};
                                            n_recyc = r_recyc | ({b[7:6], 6'd0} >> sh);
                                            n_hrun = {3'd0, len6};
                                            n_phase = srld_pkg::PH_LZ_SHORTOFF;
                                        end
                                    end else begin
                                        n_held = b;
                                        n_phase = srld_pkg::PH_LZ_LONGOFF;
                                    end
                                end
                                srld_pkg::PH_LZ_LONGRLE: begin
                                    d_len = {1'b0, b} + 9'd8;
                                    d_color = {3'd0, r_held[4:0]};
                                    n_slot = r_slot + 4'd1;
                                end
                                srld_pkg::PH_LZ_SHORTOFF: begin
                                    d_len = r_hrun[8:0];
                                    d_copy = 1'b1;
                                    d_off = {3'd0, b} + 11'd1;
                                    n_slot = r_slot + 4'd1;
                                end
                                srld_pkg::PH_LZ_LONGOFF: begin
                                    n_hrun = {r_held[7:6], b};
                                    n_phase = srld_pkg::PH_LZ_LONGLEN;
                                end
                                srld_pkg::PH_LZ_LONGLEN: begin
                                    d_len = {1'b0, b} + 9'd3;
                                    d_copy = 1'b1;
                                    d_off = {1'b0, r_hrun} + 11'd1;
                                    n_slot = r_slot + 4'd1;
                                end
                                default: begin
                                    n_ctrl = b;
                                    n_slot = '0;
                                    n_phase = srld_pkg::PH_LZ_PACKET;
                                end
                            endcase
                            // packet finished: go on with the next slot, or a new control byte after the eighth
                            if (n_slot != r_slot) begin
                                n_phase = (n_slot >= 4'd8) ? srld_pkg::PH_START
                                                           : srld_pkg::PH_LZ_PACKET;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                n_cnt = d_len;
                n_color = d_color;
                n_off = d_off;
                if (d_len == 9'd0) n_state = srld_pkg::ST_END;
                else if (d_copy)   n_state = srld_pkg::ST_CPRD;
                else               n_state = srld_pkg::ST_RUN;
            end
            srld_pkg::ST_RUN: begin
                e_pix = 1'b1;
                e_color = r_color;
                n_cnt = r_cnt - 9'd1;
                if (r_cnt == 9'd1) n_state = srld_pkg::ST_END;
            end
            srld_pkg::ST_CPRD: begin
                n_src_zero = {13'd0, r_off} > r_pos;
                if ({{(AW-11){1'b0}}, r_off} <= r_wa) begin
                    diff = {1'b0, r_wa} - {{(AW-10){1'b0}}, r_off};
                end else begin
                    diff = {1'b0, r_wa} + DEPTH_W - {{(AW-10){1'b0}}, r_off};
                end
                hist_raddr = diff[AW-1:0];
                n_state = srld_pkg::ST_CPEM;
            end
            srld_pkg::ST_CPEM: begin
                e_pix = 1'b1;
                e_color = r_src_zero ? 8'd0 : r_hist_q;
                n_cnt = r_cnt - 9'd1;
                n_state = (r_cnt == 9'd1) ? srld_pkg::ST_END : srld_pkg::ST_CPRD;
            end
            srld_pkg::ST_END: begin
                e_end = 1'b1;
                do_clear = r_last;
                n_state = srld_pkg::ST_IDLE;
            end
            default: n_state = srld_pkg::ST_IDLE;
        endcase
        if (e_pix && r_pos != srld_pkg::POS_MAX) begin
            n_pos = r_pos + 24'd1;
            n_wa = (r_wa == LAST_ADDR) ? '0 : r_wa + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srld_pkg::ST_IDLE;
        end else if (in_acc) begin
            r_state <= (i_mode == srld_pkg::MODE_PALETTE) ? srld_pkg::ST_IDLE
                                                          : srld_pkg::ST_DECODE;
        end else if (en) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_fmt || (en && do_clear)) begin
            r_phase <= srld_pkg::PH_START;
            r_skip  <= '0;
            r_pos   <= '0;
            r_wa    <= '0;
            r_ctrl  <= '0;
            r_slot  <= '0;
            r_scc   <= 2'd1;
            r_recyc <= '0;
            r_held  <= '0;
            r_hrun  <= '0;
            r_gbl   <= '0;
        end else if (en) begin
            r_phase <= n_phase;
            r_skip  <= n_skip;
            r_pos   <= n_pos;
            r_wa    <= n_wa;
            r_ctrl  <= n_ctrl;
            r_slot  <= n_slot;
            r_scc   <= n_scc;
            r_recyc <= n_recyc;
            r_held  <= n_held;
            r_hrun  <= n_hrun;
            r_gbl   <= n_gbl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= '0;
            r_surf   <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_index == srld_pkg::CFG_FORMAT) r_format <= i_cfg_data[2:0];
            if (i_cfg_index == srld_pkg::CFG_SURFACE) r_surf <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (en) begin
            r_cnt      <= n_cnt;
            r_color    <= n_color;
            r_off      <= n_off;
            r_src_zero <= n_src_zero;
        end
    end

    // pixel history: read for copies, written on every emitted pixel
    always_ff @(posedge i_clk) begin
        if (en && r_state == srld_pkg::ST_CPRD) r_hist_q <= r_hist[hist_raddr];
        if (en && e_pix) r_hist[r_wa] <= e_color;
    end

    // palette store
    always_ff @(posedge i_clk) begin
        if (in_acc && i_mode == srld_pkg::MODE_PALETTE)
            r_pal[i_palette_index] <= {i_red, i_green, i_blue};
        if (en && e_pix) r_pal_q <= r_pal[e_color];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_pix <= 1'b0;
            r_a_end <= 1'b0;
        end else if (en) begin
            r_a_pix <= e_pix;
            r_a_end <= e_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_keep <= r_pos < r_surf;
            r_a_nz   <= e_color != 8'd0;
            r_a_pos  <= r_pos;
            r_a_last <= r_last;
        end
    end

    // lane collector; a full group leaves only when the next kept pixel or the byte end shows up
    assign a_take  = r_a_pix && r_a_keep;
    assign a_pixel = {r_pal_q, r_a_nz ? 8'hFF : 8'h00};
    assign a_move  = (a_take && r_acc_cnt == 4'd8) ||
                     (r_a_end && (r_acc_cnt != 4'd0 || r_a_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_cnt <= '0;
        end else if (en) begin
            if (a_move) begin
                r_acc_cnt <= a_take ? 4'd1 : 4'd0;
            end else if (a_take) begin
                r_acc_cnt <= r_acc_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (a_move) begin
                r_acc_lane[0] <= a_pixel;
                r_acc_start   <= r_a_pos;
            end else if (a_take) begin
                r_acc_lane[r_acc_cnt[2:0]] <= a_pixel;
                if (r_acc_cnt == 4'd0) r_acc_start <= r_a_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en && a_move) begin
            r_o_vld <= 1'b1;
        end else if (r_o_vld && !i_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && a_move) begin
            for (int j = 0; j < srld_pkg::LANES; j++) begin
                r_o_lane[j] <= (4'(j) < r_acc_cnt) ? r_acc_lane[j] : 32'd0;
            end
            r_o_cnt     <= r_acc_cnt;
            r_o_start   <= (r_acc_cnt == 4'd0) ? r_a_pos : r_acc_start;
            r_o_run_end <= r_a_end;
            r_o_done    <= r_a_end && r_a_last;
        end
    end

    assign o_valid       = r_o_vld;
    assign o_start_index = r_o_start;
    assign o_pixel_count = r_o_cnt;
    assign o_lane0       = r_o_lane[0];
    assign o_lane1       = r_o_lane[1];
    assign o_lane2       = r_o_lane[2];
    assign o_lane3       = r_o_lane[3];
    assign o_lane4       = r_o_lane[4];
    assign o_lane5       = r_o_lane[5];
    assign o_lane6       = r_o_lane[6];
    assign o_lane7       = r_o_lane[7];
    assign o_run_end     = r_o_run_end;
    assign o_sprite_done = r_o_done;

`ifndef SYNTHESIS
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_cnt <= 4'd8)
        else $error("lane collector overfilled");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_done |-> r_o_run_end)
        else $error("sprite done without run end");
    a_empty_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_cnt == 4'd0 |-> r_o_done)
        else $error("empty result that does not close a sprite");
    a_end_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_a_end |=> r_acc_cnt == 4'd0)
        else $error("pixels left over after byte end");
`endif

endmodule
